// File: rtl/epwc_pkg.sv
// shared types, codes and constants for the echo pulse width capture block
// no dependencies; imported by echo_pulse_width_capture
package epwc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int REG_BITS   = 16;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [REG_BITS-1:0]   reg_t;

	// event kinds carried on cmd
	typedef enum logic [1:0] {
		CMD_TRIGGER = 2'd0,
		CMD_EDGE    = 2'd1,
		CMD_POLL    = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_FRAME_COUNTS = 2'd0,
		REG_MIN_PULSE    = 2'd1,
		REG_TIMEOUT      = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	localparam reg_t FRAME_COUNTS_RST = reg_t'(40000);
	localparam reg_t MIN_PULSE_RST    = reg_t'(20);
	localparam reg_t TIMEOUT_RST      = reg_t'(30000);

	// one result item
	typedef struct packed {
		logic       complete;
		logic [15:0] pulse_us;
		logic       measuring;
	} res_t;

	// wrap-safe count difference, taken modulo the frame length
	function automatic count_t wrap_delta(input count_t now, input count_t start,
			input reg_t frame);
		count_t frame_c;
		frame_c = count_t'(frame);
		if (now >= start)
			return count_t'(now - start);
		else
			return count_t'(frame_c - start + now);
	endfunction

	// ticks halved, rounded up at one half
	function automatic logic [15:0] half_round(input count_t ticks);
		logic [COUNT_BITS:0] sum;
		sum = {1'b0, ticks} + {{COUNT_BITS{1'b0}}, 1'b1};
		return 16'(sum >> 1);
	endfunction

endpackage

// File: rtl/echo_pulse_width_capture.sv
// top level of the echo pulse width capture block
// depends on epwc_pkg (types, event codes, wrap-safe difference)
module echo_pulse_width_capture
	import epwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// event channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] timer_value,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        complete,
	output logic [15:0] pulse_us,
	output logic        measuring
);

	// Measures an ultrasonic echo pulse from a shared timer that wraps every
	// frame_counts counts. Each event transaction (trigger, edge capture, poll,
	// read) yields exactly one result transaction carrying the complete flag,
	// the stored width in microseconds and the in-flight flag as they stand
	// after that event. An accepted event sits in one input register; once the
	// output queue has room, the measurement state is updated and the result is
	// written into that two-entry queue. One event per cycle is sustained while
	// the queue has room; on its way to the result each event passes the input
	// register and the output queue register. The queue holds up to two results
	// for the consumer; with both full and none leaving, the staged event stalls.
	// Configuration writes are taken every cycle (cfg_ready is always high); an
	// index of three is ignored. Configure only while no event is outstanding.

	// configuration registers
	reg_t frame_counts_q;
	reg_t min_pulse_q;
	reg_t timeout_q;

	// measurement state
	count_t      trigger_count_q;
	count_t      rise_count_q;
	logic        await_rise_q;
	logic        in_flight_q;
	logic        done_flag_q;
	logic [15:0] width_us_q;

	// input stage
	logic   valid_s1;
	cmd_t   cmd_s1;
	count_t tv_s1;

	// output queue
	res_t       q0_q;
	res_t       q1_q;
	logic [1:0] count_q;

	logic pop;
	logic push;

	// next-state values
	count_t      trigger_count_d;
	count_t      rise_count_d;
	logic        await_rise_d;
	logic        in_flight_d;
	logic        done_flag_d;
	logic [15:0] width_us_d;
	count_t      edge_ticks;
	count_t      poll_ticks;
	res_t        res;

	assign cfg_ready = 1'b1;

	// result leaves the head of the queue
	assign pop  = (count_q != 2'd0) && out_ready;
	// the staged event moves on when the queue has room
	assign push = valid_s1 && ((count_q != 2'd2) || pop);
	assign in_ready = !valid_s1 || push;

	assign out_valid = (count_q != 2'd0);
	assign complete  = q0_q.complete;
	assign pulse_us  = q0_q.pulse_us;
	assign measuring = q0_q.measuring;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counts_q <= FRAME_COUNTS_RST;
			min_pulse_q    <= MIN_PULSE_RST;
			timeout_q      <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_COUNTS: frame_counts_q <= cfg_data;
				REG_MIN_PULSE:    min_pulse_q    <= cfg_data;
				REG_TIMEOUT:      timeout_q      <= cfg_data;
				default:          ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_t'(cmd);
			tv_s1  <= count_t'(timer_value);
		end
	end

	// event processing on the staged item
	assign edge_ticks = wrap_delta(tv_s1, rise_count_q, frame_counts_q);
	assign poll_ticks = wrap_delta(tv_s1, trigger_count_q, frame_counts_q);

	always_comb begin
		trigger_count_d = trigger_count_q;
		rise_count_d    = rise_count_q;
		await_rise_d    = await_rise_q;
		in_flight_d     = in_flight_q;
		done_flag_d     = done_flag_q;
		width_us_d      = width_us_q;
		unique case (cmd_s1)
			CMD_TRIGGER: begin
				done_flag_d     = 1'b0;
				await_rise_d    = 1'b1;
				in_flight_d     = 1'b1;
				trigger_count_d = tv_s1;
			end
			CMD_EDGE: begin
				if (await_rise_q) begin
					rise_count_d = tv_s1;
					await_rise_d = 1'b0;
				end else begin
					await_rise_d = 1'b1;
					// short pulses are dropped as noise
					if (edge_ticks >= count_t'(min_pulse_q)) begin
						width_us_d  = half_round(edge_ticks);
						done_flag_d = 1'b1;
						in_flight_d = 1'b0;
					end
				end
			end
			CMD_POLL: begin
				// timeout: no echo within the allowed span
				if (in_flight_q && (poll_ticks > count_t'(timeout_q))) begin
					in_flight_d  = 1'b0;
					width_us_d   = 16'd0;
					done_flag_d  = 1'b1;
					await_rise_d = 1'b1;
				end
			end
			CMD_READ: begin
				done_flag_d = 1'b0;
			end
			default: ;
		endcase
		res.complete  = done_flag_d;
		res.pulse_us  = width_us_d;
		res.measuring = in_flight_d;
	end

	// state update when the staged event is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_count_q <= '0;
			rise_count_q    <= '0;
			await_rise_q    <= 1'b1;
			in_flight_q     <= 1'b0;
			done_flag_q     <= 1'b0;
			width_us_q      <= 16'd0;
		end else if (push) begin
			trigger_count_q <= trigger_count_d;
			rise_count_q    <= rise_count_d;
			await_rise_q    <= await_rise_d;
			in_flight_q     <= in_flight_d;
			done_flag_q     <= done_flag_d;
			width_us_q      <= width_us_d;
		end
	end

	// output queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// output queue entries, head in q0
	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0)
					q0_q <= res;
				else
					q1_q <= res;
			end
			2'b01: begin
				q0_q <= q1_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					q0_q <= res;
				end else begin
					q0_q <= q1_q;
					q1_q <= res;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/epwc_checker.sv
// port-level checks for echo_pulse_width_capture
// no package dependencies; bound to the top level at the end of this file
module epwc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        complete,
	input logic [15:0] pulse_us,
	input logic        measuring
);

	// stalled result transaction keeps its valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// stalled result payload stays put
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(complete) && $stable(pulse_us)
			&& $stable(measuring))
		else $error("result payload changed while stalled");

	// a finished measurement is never also in flight
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(complete && measuring))
		else $error("complete and measuring both set");

	// halved width never exceeds half the counter range
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_us <= 16'd32768)
		else $error("pulse width out of range");

	// configuration port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind echo_pulse_width_capture epwc_checker u_epwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.complete  (complete),
	.pulse_us  (pulse_us),
	.measuring (measuring)
);
